/* sv/dcs_pkg.sv */
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the drifting clock synchronizer.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned TICK_W   = 31;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_W    = 31;

  localparam logic [TIME_W-1:0]   NO_OFFSET     = 32'h7FFF_FFFF;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD    = 16'd6;
  localparam logic [TICK_W-1:0]   TICK_INC_RST  = 31'd65536;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd1000;

  // configuration register indexes
  localparam logic REG_TICK_INCREMENT = 1'b0;
  localparam logic REG_ADJUST_PERIOD  = 1'b1;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/drifting_clock_sync_top.sv */
// ----------------------------------------------------------------------------
// drifting_clock_sync_top
// Smooth clock in ms/65536 that follows a late-but-never-early measured
// millisecond time, retuning its increment once per adjust period.
// ----------------------------------------------------------------------------
// One item is taken at a time and in_stall stays high until its result has
// been taken. A start item goes straight to the output register, its result
// offered on the cycle after acceptance; an ordinary tick passes through the
// advance and offset states before its result is offered. The tick that ends an
// adjust period also passes the adjust and difference states and runs the
// serial divider, 32 quotient bits one a cycle plus setup and sign fix-up.
// The result waits in an output register for as long as out_stall holds.
// ----------------------------------------------------------------------------
module drifting_clock_sync_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_index,
  input  logic [dcs_pkg::CFG_W-1:0]             cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic [dcs_pkg::MS_W-1:0]              in_measured_ms,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dcs_pkg::TIME_W-1:0]     out_clock_value
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADV   = 3'd1;
  localparam logic [2:0] ST_OFF   = 3'd2;
  localparam logic [2:0] ST_ADJ   = 3'd3;
  localparam logic [2:0] ST_DIFF  = 3'd4;
  localparam logic [2:0] ST_DIVGO = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]                       state_r, state_nxt;
  logic [dcs_pkg::TICK_W-1:0]       tick_inc_r;
  logic [dcs_pkg::PERIOD_W-1:0]     period_r;
  logic [dcs_pkg::TIME_W-1:0]       clock_r, clock_nxt;
  logic [dcs_pkg::TIME_W-1:0]       cstep_r, cstep_nxt;
  logic [dcs_pkg::TIME_W-1:0]       target_r, target_nxt;
  logic [dcs_pkg::TIME_W-1:0]       tstep_r, tstep_nxt;
  logic [dcs_pkg::TIME_W-1:0]       min_off_r, min_off_nxt;
  logic [dcs_pkg::PERIOD_W-1:0]     countdown_r, countdown_nxt;
  logic [dcs_pkg::TIME_W-1:0]       meas_r, meas_nxt;
  logic [dcs_pkg::TIME_W-1:0]       diff_r, diff_nxt;
  logic [dcs_pkg::PERIOD_W-1:0]     period;
  logic [dcs_pkg::TIME_W-1:0]       offset;
  logic [dcs_pkg::TIME_W-1:0]       start_time;
  logic                             accept;
  logic                             div_start;
  logic [dcs_pkg::TIME_W-1:0]       div_quo;
  dcs_pkg::div_stat_t               div_stat;

  assign period     = (period_r < dcs_pkg::MIN_PERIOD) ? dcs_pkg::MIN_PERIOD : period_r;
  assign accept     = in_valid && !in_stall;
  assign offset     = meas_r - target_r;
  assign start_time = {in_measured_ms, 16'd0};
  assign div_start  = (state_r == ST_DIVGO);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_inc_r <= dcs_pkg::TICK_INC_RST;
      period_r   <= dcs_pkg::PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dcs_pkg::REG_TICK_INCREMENT: tick_inc_r <= cfg_wr_data;
        dcs_pkg::REG_ADJUST_PERIOD:  period_r   <= cfg_wr_data[dcs_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    cstep_nxt     = cstep_r;
    target_nxt    = target_r;
    tstep_nxt     = tstep_r;
    min_off_nxt   = min_off_r;
    countdown_nxt = countdown_r;
    meas_nxt      = meas_r;
    diff_nxt      = diff_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          meas_nxt = start_time;
          if (in_operation == dcs_pkg::OP_START) begin
            clock_nxt     = start_time;
            target_nxt    = start_time;
            cstep_nxt     = {1'b0, tick_inc_r};
            tstep_nxt     = {1'b0, tick_inc_r};
            min_off_nxt   = dcs_pkg::NO_OFFSET;
            countdown_nxt = period;
            state_nxt     = ST_OUT;
          end else begin
            state_nxt = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        clock_nxt  = clock_r + cstep_r;
        target_nxt = target_r + tstep_r;
        state_nxt  = ST_OFF;
      end
      ST_OFF: begin
        if ($signed(offset) < $signed(min_off_r)) begin
          min_off_nxt = offset;
        end
        if (countdown_r <= 16'd1) begin
          state_nxt = ST_ADJ;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
          state_nxt     = ST_OUT;
        end
      end
      ST_ADJ: begin
        target_nxt  = target_r + min_off_r;
        min_off_nxt = dcs_pkg::NO_OFFSET;
        state_nxt   = ST_DIFF;
      end
      ST_DIFF: begin
        diff_nxt  = target_r - clock_r;
        state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          cstep_nxt     = tstep_r + div_quo;
          countdown_nxt = period;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_r     <= '0;
      cstep_r     <= '0;
      target_r    <= '0;
      tstep_r     <= '0;
      min_off_r   <= dcs_pkg::NO_OFFSET;
      countdown_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      cstep_r     <= cstep_nxt;
      target_r    <= target_nxt;
      tstep_r     <= tstep_nxt;
      min_off_r   <= min_off_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r <= meas_nxt;
    diff_r <= diff_nxt;
  end

  dcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_r),
    .divisor  (period),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_clock_value = $signed(clock_r);

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while an item waits at the output");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV))
    else $error("divider running outside the divide state");
  a_start_loads_period: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == dcs_pkg::OP_START) |=> (countdown_r == $past(period)))
    else $error("start did not reload the countdown");
  a_min_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVGO) |-> (min_off_r == dcs_pkg::NO_OFFSET))
    else $error("minimum offset not cleared at resync");
`endif

endmodule

/* sv/dcs_div.sv */
// ----------------------------------------------------------------------------
// dcs_div
// Serial signed divider: 32-bit dividend by unsigned 16-bit divisor,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module dcs_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [dcs_pkg::TIME_W-1:0]           dividend,
  input  logic [dcs_pkg::PERIOD_W-1:0]         divisor,
  output logic [dcs_pkg::TIME_W-1:0]           quotient,
  output dcs_pkg::div_stat_t                   stat
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [5:0]                        cnt_r, cnt_nxt;
  logic [dcs_pkg::PERIOD_W-1:0]      rem_r, rem_nxt;
  logic [dcs_pkg::TIME_W-1:0]        quo_r, quo_nxt;
  logic [dcs_pkg::TIME_W-1:0]        res_r, res_nxt;
  logic [dcs_pkg::PERIOD_W-1:0]      dvs_r, dvs_nxt;
  logic                              neg_r, neg_nxt;
  logic [dcs_pkg::PERIOD_W:0]        trial;
  logic                              fits;

  assign trial = {rem_r, quo_r[dcs_pkg::TIME_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    res_nxt  = res_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[dcs_pkg::TIME_W-1];
      quo_nxt  = dividend[dcs_pkg::TIME_W-1] ? (~dividend + 32'd1) : dividend;
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        // sign fix-up of the magnitude quotient
        res_nxt  = neg_r ? (~quo_r + 32'd1) : quo_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = fits ? (trial[dcs_pkg::PERIOD_W-1:0] - dvs_r)
                       : trial[dcs_pkg::PERIOD_W-1:0];
        quo_nxt = {quo_r[dcs_pkg::TIME_W-2:0], fits};
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    res_r <= res_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign quotient  = res_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("divider busy and done together");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r != 6'd0) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");
`endif

endmodule
